// File: rtl/cda_pkg.sv
// ----------------------------------------------------------------------------
// cda_pkg
// Shared types and codes for the column dependency admission table.
// ----------------------------------------------------------------------------
`default_nettype none

package cda_pkg;

  localparam int KEY_W = 24;
  localparam int TB_W  = 12;

  localparam logic MODE_PUSH   = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;
  localparam logic [1:0] ST_UNKNOWN  = 2'd3;

  localparam logic [4:0] SLOT_LIMIT_RST = 5'd16;

  typedef struct packed {
    logic        mode;
    logic [7:0]  kernel_tag;
    logic [15:0] launch_tag;
    logic [3:0]  column_type;
    logic [7:0]  body_id;
    logic [15:0] column_id;
  } cda_in_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] assigned_id;
    logic [1:0]  status;
    logic [4:0]  columns_in_use;
  } cda_out_t;

  typedef struct packed {
    logic key_hit;
    logic key_free;
    logic slot_free;
    logic slot_hit;
  } cda_flags_t;

endpackage

`default_nettype wire

// File: rtl/cda_ram.sv
// ----------------------------------------------------------------------------
// cda_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire logic [WIDTH-1:0]    wdata_i,
  input  wire logic [AW-1:0]       raddr_i,
  output logic      [WIDTH-1:0]    rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/cda_scan.sv
// ----------------------------------------------------------------------------
// cda_scan
// Shared compare unit: matches one table entry per cycle against the
// current item and keeps the first key hit, slot hit and free entries.
// ----------------------------------------------------------------------------
`default_nettype none

module cda_scan
  import cda_pkg::*;
#(
  parameter int IDX_W   = 4,
  parameter int CNT_W   = 5,
  parameter int ID_BITS = 16,
  parameter int CMP_W   = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clear_i,
  input  wire logic               eval_i,
  input  wire logic [IDX_W-1:0]   idx_i,
  input  wire logic               slot_vld_i,
  input  wire logic               key_vld_i,
  input  wire logic [ID_BITS-1:0] slot_id_i,
  input  wire logic [IDX_W-1:0]   slot_kidx_i,
  input  wire logic [KEY_W-1:0]   key_value_i,
  input  wire logic [TB_W-1:0]    key_tb_i,
  input  wire logic [CNT_W-1:0]   key_cnt_i,
  input  wire logic [KEY_W-1:0]   tgt_key_i,
  input  wire logic [CMP_W-1:0]   tgt_id_i,
  output cda_flags_t              flags_o,
  output logic      [IDX_W-1:0]   key_hit_idx_o,
  output logic      [TB_W-1:0]    key_hit_tb_o,
  output logic      [CNT_W-1:0]   key_hit_cnt_o,
  output logic      [IDX_W-1:0]   key_free_idx_o,
  output logic      [IDX_W-1:0]   slot_free_idx_o,
  output logic      [IDX_W-1:0]   slot_hit_idx_o,
  output logic      [IDX_W-1:0]   slot_hit_kidx_o
);

  cda_flags_t flags_d, flags_q;
  logic       key_match, slot_match;
  logic       take_key_hit, take_key_free, take_slot_free, take_slot_hit;

  assign key_match  = key_vld_i && (key_value_i == tgt_key_i);
  assign slot_match = slot_vld_i && (CMP_W'(slot_id_i) == tgt_id_i);

  assign take_key_hit   = eval_i && key_match && !flags_q.key_hit;
  assign take_key_free  = eval_i && !key_vld_i && !flags_q.key_free;
  assign take_slot_free = eval_i && !slot_vld_i && !flags_q.slot_free;
  assign take_slot_hit  = eval_i && slot_match && !flags_q.slot_hit;

  always_comb begin
    flags_d = flags_q;
    if (clear_i) begin
      flags_d = '0;
    end else begin
      if (take_key_hit)   flags_d.key_hit   = 1'b1;
      if (take_key_free)  flags_d.key_free  = 1'b1;
      if (take_slot_free) flags_d.slot_free = 1'b1;
      if (take_slot_hit)  flags_d.slot_hit  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_key_hit) begin
      key_hit_idx_o <= idx_i;
      key_hit_tb_o  <= key_tb_i;
      key_hit_cnt_o <= key_cnt_i;
    end
    if (take_key_free) begin
      key_free_idx_o <= idx_i;
    end
    if (take_slot_free) begin
      slot_free_idx_o <= idx_i;
    end
    if (take_slot_hit) begin
      slot_hit_idx_o  <= idx_i;
      slot_hit_kidx_o <= slot_kidx_i;
    end
  end

  assign flags_o = flags_q;

endmodule

`default_nettype wire

// File: rtl/column_dependency_admission.sv
// ----------------------------------------------------------------------------
// column_dependency_admission
// Admission and retirement table for instruction columns: pushes take a slot
// and a use of a key entry, finishes free both, all under a scanning sequencer.
// ----------------------------------------------------------------------------
//  channel   signals                      direction  handshake
//  item      start, busy, item_i          in         start & !busy
//  result    res_valid_o, res_o           out        one-cycle strobe
//  config    cfg_valid_i, cfg_ready_o,    in         valid & ready
//            cfg_data_i
//
//  A push is decided in S_DECIDE after the scan, a hitting finish in S_RETIRE
//  after S_FETCH; the result strobe follows in the next cycle. The scan sets
//  the time; it reads one slot and one key entry per cycle via the compare unit.
//  Reset empties the table at once through the valid bits; no clearing pass.
//  The result cannot be stalled; busy holds off items until it is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module column_dependency_admission
  import cda_pkg::*;
#(
  parameter int MAX_COLUMNS = 16,
  parameter int ID_BITS     = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire cda_in_t    item_i,
  output logic            busy,
  output logic            res_valid_o,
  output cda_out_t        res_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [4:0] cfg_data_i
);

  localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W = $clog2(MAX_COLUMNS + 1);
  localparam int LIM_W = (CNT_W > 5) ? CNT_W : 5;
  localparam int CMP_W = (ID_BITS > 16) ? ID_BITS : 16;
  localparam int KW    = KEY_W + TB_W + CNT_W;
  localparam int SW    = ID_BITS + IDX_W;

  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(MAX_COLUMNS);
  localparam logic [LIM_W-1:0] N_LIM = LIM_W'(MAX_COLUMNS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_RETIRE = 3'd4;

  logic [2:0]             state_d, state_q;
  logic [CNT_W-1:0]       idx_d, idx_q;
  logic                   ev_vld_d, ev_vld_q;
  logic [IDX_W-1:0]       ev_idx_d, ev_idx_q;
  cda_in_t                item_q;
  logic [MAX_COLUMNS-1:0] slot_vld_d, slot_vld_q;
  logic [MAX_COLUMNS-1:0] key_vld_d, key_vld_q;
  logic [ID_BITS-1:0]     nid_d, nid_q;
  logic [CNT_W-1:0]       live_d, live_q;
  logic [4:0]             lim_d, lim_q;
  logic                   res_valid_d, res_valid_q;
  logic                   res_acc_d, res_acc_q;
  logic [15:0]            res_id_d, res_id_q;
  logic [1:0]             res_st_d, res_st_q;

  logic                   accept, scan_issue, eval;
  logic [KEY_W-1:0]       tgt_key;
  logic [TB_W-1:0]        tgt_tb;
  logic [CMP_W-1:0]       tgt_id;
  logic [CMP_W-1:0]       nid_ext;
  logic [LIM_W-1:0]       lim_ext, lim_eff, live_ext;
  logic                   full;

  logic                   slot_we, key_we;
  logic [IDX_W-1:0]       slot_waddr, key_waddr, rd_addr;
  logic [SW-1:0]          slot_wdata, slot_rdata;
  logic [KW-1:0]          key_wdata, key_rdata;

  logic [ID_BITS-1:0]     rd_slot_id;
  logic [IDX_W-1:0]       rd_slot_kidx;
  logic [KEY_W-1:0]       rd_key_value;
  logic [TB_W-1:0]        rd_key_tb;
  logic [CNT_W-1:0]       rd_key_cnt;

  cda_flags_t             flags;
  logic [IDX_W-1:0]       key_hit_idx, key_free_idx, slot_free_idx;
  logic [IDX_W-1:0]       slot_hit_idx, slot_hit_kidx, kidx_sel;
  logic [TB_W-1:0]        key_hit_tb;
  logic [CNT_W-1:0]       key_hit_cnt, inc_cnt, dec_cnt;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;

  assign scan_issue = (state_q == S_SCAN) && (idx_q != N_CNT);
  assign eval       = (state_q == S_SCAN) && ev_vld_q;
  assign rd_addr    = (state_q == S_FETCH) ? slot_hit_kidx : idx_q[IDX_W-1:0];

  assign tgt_key = {item_q.kernel_tag, item_q.launch_tag};
  assign tgt_tb  = {item_q.column_type, item_q.body_id};
  assign tgt_id  = CMP_W'(item_q.column_id);
  assign nid_ext = CMP_W'(nid_q);

  assign lim_ext  = LIM_W'(lim_q);
  assign lim_eff  = (lim_ext > N_LIM) ? N_LIM : lim_ext;
  assign live_ext = LIM_W'(live_q);
  assign full     = (live_ext >= lim_eff);

  assign rd_slot_id   = slot_rdata[SW-1 -: ID_BITS];
  assign rd_slot_kidx = slot_rdata[IDX_W-1:0];
  assign rd_key_value = key_rdata[KW-1 -: KEY_W];
  assign rd_key_tb    = key_rdata[CNT_W +: TB_W];
  assign rd_key_cnt   = key_rdata[CNT_W-1:0];

  assign kidx_sel = flags.key_hit ? key_hit_idx : key_free_idx;
  assign inc_cnt  = key_hit_cnt + CNT_W'(1);
  assign dec_cnt  = (rd_key_cnt != '0) ? rd_key_cnt - CNT_W'(1) : '0;

  cda_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_COLUMNS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (rd_addr),
    .rdata_o (slot_rdata)
  );

  cda_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_COLUMNS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  cda_scan #(
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W),
    .ID_BITS (ID_BITS),
    .CMP_W   (CMP_W)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clear_i         (accept),
    .eval_i          (eval),
    .idx_i           (ev_idx_q),
    .slot_vld_i      (slot_vld_q[ev_idx_q]),
    .key_vld_i       (key_vld_q[ev_idx_q]),
    .slot_id_i       (rd_slot_id),
    .slot_kidx_i     (rd_slot_kidx),
    .key_value_i     (rd_key_value),
    .key_tb_i        (rd_key_tb),
    .key_cnt_i       (rd_key_cnt),
    .tgt_key_i       (tgt_key),
    .tgt_id_i        (tgt_id),
    .flags_o         (flags),
    .key_hit_idx_o   (key_hit_idx),
    .key_hit_tb_o    (key_hit_tb),
    .key_hit_cnt_o   (key_hit_cnt),
    .key_free_idx_o  (key_free_idx),
    .slot_free_idx_o (slot_free_idx),
    .slot_hit_idx_o  (slot_hit_idx),
    .slot_hit_kidx_o (slot_hit_kidx)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ev_vld_d    = scan_issue;
    ev_idx_d    = idx_q[IDX_W-1:0];
    slot_vld_d  = slot_vld_q;
    key_vld_d   = key_vld_q;
    nid_d       = nid_q;
    live_d      = live_q;
    lim_d       = lim_q;
    res_valid_d = 1'b0;
    res_acc_d   = res_acc_q;
    res_id_d    = res_id_q;
    res_st_d    = res_st_q;
    slot_we     = 1'b0;
    slot_waddr  = slot_free_idx;
    slot_wdata  = {nid_q, kidx_sel};
    key_we      = 1'b0;
    key_waddr   = kidx_sel;
    key_wdata   = {tgt_key, tgt_tb, flags.key_hit ? inc_cnt : CNT_W'(1)};

    if (cfg_valid_i && cfg_ready_o) begin
      lim_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_SCAN;
          idx_d   = '0;
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          idx_d = idx_q + CNT_W'(1);
        end else if (!ev_vld_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (item_q.mode == MODE_PUSH) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          res_acc_d   = 1'b0;
          res_id_d    = '0;
          if (full) begin
            res_st_d = ST_FULL;
          end else if (flags.key_hit && (key_hit_tb != tgt_tb)) begin
            res_st_d = ST_CONFLICT;
          end else if (!flags.slot_free || (!flags.key_hit && !flags.key_free)) begin
            res_st_d = ST_FULL;
          end else begin
            slot_we                   = 1'b1;
            key_we                    = 1'b1;
            slot_vld_d[slot_free_idx] = 1'b1;
            key_vld_d[kidx_sel]       = 1'b1;
            nid_d                     = nid_q + ID_BITS'(1);
            live_d                    = live_q + CNT_W'(1);
            res_acc_d                 = 1'b1;
            res_id_d                  = nid_ext[15:0];
            res_st_d                  = ST_OK;
          end
        end else if (!flags.slot_hit) begin
          state_d     = S_IDLE;
          res_valid_d = 1'b1;
          res_acc_d   = 1'b0;
          res_id_d    = '0;
          res_st_d    = ST_UNKNOWN;
        end else begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_RETIRE;
      end
      S_RETIRE: begin
        state_d                  = S_IDLE;
        key_we                   = 1'b1;
        key_waddr                = slot_hit_kidx;
        key_wdata                = {rd_key_value, rd_key_tb, dec_cnt};
        if (dec_cnt == '0) begin
          key_vld_d[slot_hit_kidx] = 1'b0;
        end
        slot_vld_d[slot_hit_idx] = 1'b0;
        if (live_q != '0) begin
          live_d = live_q - CNT_W'(1);
        end
        res_valid_d = 1'b1;
        res_acc_d   = 1'b1;
        res_id_d    = '0;
        res_st_d    = ST_OK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      ev_vld_q    <= 1'b0;
      slot_vld_q  <= '0;
      key_vld_q   <= '0;
      nid_q       <= '0;
      live_q      <= '0;
      lim_q       <= SLOT_LIMIT_RST;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      ev_vld_q    <= ev_vld_d;
      slot_vld_q  <= slot_vld_d;
      key_vld_q   <= key_vld_d;
      nid_q       <= nid_d;
      live_q      <= live_d;
      lim_q       <= lim_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q  <= ev_idx_d;
    res_acc_q <= res_acc_d;
    res_id_q  <= res_id_d;
    res_st_q  <= res_st_d;
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign res_valid_o = res_valid_q;

  always_comb begin
    res_o.accepted       = res_acc_q;
    res_o.assigned_id    = res_id_q;
    res_o.status         = res_st_q;
    res_o.columns_in_use = live_ext[4:0];
  end

  a_res_after_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q == S_DECIDE || state_q == S_RETIRE))
    else $error("result strobe without a decision");

  a_live_matches_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_vld_q) == int'(live_q))
    else $error("live count out of step with slot valid bits");

  a_keys_within_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(key_vld_q) <= $countones(slot_vld_q))
    else $error("more live keys than live columns");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !res_valid_o)
    else $error("sequencer not busy after taking an item");

endmodule

`default_nettype wire

// File: test/tb_column_dependency_admission.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_dependency_admission
// Drives push and finish items into the column admission table, first from a
// short table of directed rows and then in random phases under several slot
// limits, and checks each result strobe against fixed values or a table predictor.
// ----------------------------------------------------------------------------
module tb_column_dependency_admission;
  import cda_pkg::*;

  localparam int MAX_COLUMNS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = MAX_COLUMNS + 16;
  localparam int PHASE_ITEMS = 313;
  localparam int PHASES      = 6;
  localparam int POOL        = 6;

  typedef struct {
    bit         is_cfg;
    logic [4:0] cfg;
    cda_in_t    it;
    bit         fixed;
    cda_out_t   want;
  } step_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  cda_in_t    item_i      = '0;
  logic       cfg_valid_i = 1'b0;
  logic [4:0] cfg_data_i  = '0;
  logic       busy;
  logic       res_valid_o;
  logic       cfg_ready_o;
  cda_out_t   res_o;

  // predicted table contents
  logic        col_valid [MAX_COLUMNS];
  logic [15:0] col_id    [MAX_COLUMNS];
  logic [23:0] col_key   [MAX_COLUMNS];
  logic        key_live  [MAX_COLUMNS];
  logic [23:0] key_val   [MAX_COLUMNS];
  logic [11:0] key_tb    [MAX_COLUMNS];
  logic [4:0]  key_cnt   [MAX_COLUMNS];
  logic [15:0] next_id;
  logic [4:0]  live_cols;
  logic [4:0]  limit_reg;

  logic [23:0] pool_key [POOL];
  logic [11:0] pool_tb  [POOL];

  cda_out_t pending_results [$];
  cda_out_t due;
  step_t    steps [$];
  int       mismatches = 0;
  int       cycles     = 0;
  bit       idle_on    = 1'b1;

  always #4 clk_i = ~clk_i;

  column_dependency_admission #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .ID_BITS    (16)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .item_i     (item_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  function automatic cda_out_t admit_or_retire(cda_in_t it);
    cda_out_t    r;
    logic [23:0] key;
    logic [11:0] tb;
    int          limit, k, kf, s, i;
    r     = '0;
    key   = {it.kernel_tag, it.launch_tag};
    tb    = {it.column_type, it.body_id};
    limit = (limit_reg > MAX_COLUMNS) ? MAX_COLUMNS : limit_reg;
    k     = -1;
    kf    = -1;
    s     = -1;
    if (it.mode == MODE_PUSH) begin
      for (i = MAX_COLUMNS - 1; i >= 0; i--) begin
        if (key_live[i] && key_val[i] == key) k = i;
        if (!key_live[i]) kf = i;
        if (!col_valid[i]) s = i;
      end
      if (live_cols >= limit) begin
        r.status = ST_FULL;
      end else if (k >= 0 && key_tb[k] != tb) begin
        r.status = ST_CONFLICT;
      end else if (s < 0 || (k < 0 && kf < 0)) begin
        r.status = ST_FULL;
      end else begin
        if (k < 0) begin
          k           = kf;
          key_live[k] = 1'b1;
          key_val[k]  = key;
          key_tb[k]   = tb;
          key_cnt[k]  = 5'd1;
        end else begin
          key_cnt[k] = key_cnt[k] + 5'd1;
        end
        col_valid[s]  = 1'b1;
        col_id[s]     = next_id;
        col_key[s]    = key;
        r.accepted    = 1'b1;
        r.assigned_id = next_id;
        r.status      = ST_OK;
        next_id       = next_id + 16'd1;
        live_cols     = live_cols + 5'd1;
      end
    end else begin
      for (i = MAX_COLUMNS - 1; i >= 0; i--)
        if (col_valid[i] && col_id[i] == it.column_id) s = i;
      if (s < 0) begin
        r.status = ST_UNKNOWN;
      end else begin
        for (i = MAX_COLUMNS - 1; i >= 0; i--)
          if (key_live[i] && key_val[i] == col_key[s]) k = i;
        if (k >= 0) begin
          if (key_cnt[k] != 0) key_cnt[k] = key_cnt[k] - 5'd1;
          if (key_cnt[k] == 0) key_live[k] = 1'b0;
        end
        col_valid[s] = 1'b0;
        if (live_cols != 0) live_cols = live_cols - 5'd1;
        r.accepted = 1'b1;
        r.status   = ST_OK;
      end
    end
    r.columns_in_use = live_cols;
    return r;
  endfunction

  function automatic cda_in_t random_item();
    cda_in_t     it;
    logic [63:0] noise;
    logic [15:0] live_ids [MAX_COLUMNS];
    int          limit, n, p, pick, i;
    noise = {$urandom, $urandom};
    it    = noise[$bits(cda_in_t)-1:0];
    limit = (limit_reg > MAX_COLUMNS) ? MAX_COLUMNS : limit_reg;
    n     = 0;
    it.mode = ($urandom_range(0, 99) < ((live_cols >= limit) ? 60 : 40)) ?
              MODE_FINISH : MODE_PUSH;
    if (it.mode == MODE_PUSH) begin
      pick = $urandom_range(0, 99);
      p    = $urandom_range(0, POOL - 1);
      if (pick < 88) {it.kernel_tag, it.launch_tag} = pool_key[p];
      if (pick < 75) {it.column_type, it.body_id} = pool_tb[p];
    end else if (live_cols != 0 && $urandom_range(0, 99) < 85) begin
      for (i = 0; i < MAX_COLUMNS; i++)
        if (col_valid[i]) begin
          live_ids[n] = col_id[i];
          n++;
        end
      if (n != 0) it.column_id = live_ids[$urandom_range(0, n - 1)];
    end
    return it;
  endfunction

  function automatic step_t predicted(cda_in_t it);
    step_t r;
    r = '{1'b0, 5'd0, it, 1'b0, '0};
    return r;
  endfunction

  function automatic step_t known(cda_in_t it, cda_out_t want);
    step_t r;
    r = '{1'b0, 5'd0, it, 1'b1, want};
    return r;
  endfunction

  function automatic step_t limit_row(logic [4:0] v);
    step_t r;
    r = '{1'b1, v, '0, 1'b0, '0};
    return r;
  endfunction

  task automatic add_row(step_t row);
    steps.insert(steps.size(), row);
  endtask

  task automatic issue(cda_in_t it, bit fixed, cda_out_t want);
    cda_out_t p;
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    p = admit_or_retire(it);
    pending_results.insert(pending_results.size(), fixed ? want : p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic quiesce();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [4:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_reg = v;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result at cycle %0d: acc %0d id %0d status %0d live %0d",
                   cycles, res_o.accepted, res_o.assigned_id, res_o.status,
                   res_o.columns_in_use);
      end else begin
        due = pending_results.pop_front();
        if (res_o.accepted !== due.accepted || res_o.assigned_id !== due.assigned_id ||
            res_o.status !== due.status || res_o.columns_in_use !== due.columns_in_use) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch at cycle %0d: expected acc %0d id %0d status %0d live %0d,",
                   cycles, due.accepted, due.assigned_id, due.status, due.columns_in_use);
            $display(" got acc %0d id %0d status %0d live %0d",
                     res_o.accepted, res_o.assigned_id, res_o.status, res_o.columns_in_use);
          end
        end
      end
    end
  end

  initial begin
    logic [4:0] phase_limit [PHASES];
    int         i, p;
    for (i = 0; i < MAX_COLUMNS; i++) begin
      col_valid[i] = 1'b0;
      col_id[i]    = '0;
      col_key[i]   = '0;
      key_live[i]  = 1'b0;
      key_val[i]   = '0;
      key_tb[i]    = '0;
      key_cnt[i]   = '0;
    end
    next_id   = '0;
    live_cols = '0;
    limit_reg = SLOT_LIMIT_RST;

    add_row(known({MODE_FINISH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'h0000},
                  {1'b0, 16'd0, ST_UNKNOWN, 5'd0}));
    add_row(known({MODE_PUSH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'hFFFF},
                  {1'b1, 16'd0, ST_OK, 5'd1}));
    add_row(known({MODE_PUSH, 8'hFF, 16'hFFFF, 4'hF, 8'hFF, 16'h0000},
                  {1'b1, 16'd1, ST_OK, 5'd2}));
    add_row(known({MODE_PUSH, 8'hFF, 16'hFFFF, 4'hE, 8'hFF, 16'h0000},
                  {1'b0, 16'd0, ST_CONFLICT, 5'd2}));
    add_row(known({MODE_PUSH, 8'hFF, 16'hFFFF, 4'hF, 8'h00, 16'h0000},
                  {1'b0, 16'd0, ST_CONFLICT, 5'd2}));
    add_row(known({MODE_PUSH, 8'hFF, 16'hFFFF, 4'hF, 8'hFF, 16'hFFFF},
                  {1'b1, 16'd2, ST_OK, 5'd3}));
    add_row(known({MODE_FINISH, 8'hFF, 16'hFFFF, 4'hF, 8'hFF, 16'h0001},
                  {1'b1, 16'd0, ST_OK, 5'd2}));
    add_row(known({MODE_FINISH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'h0001},
                  {1'b0, 16'd0, ST_UNKNOWN, 5'd2}));
    add_row(known({MODE_FINISH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'hFFFF},
                  {1'b0, 16'd0, ST_UNKNOWN, 5'd2}));
    add_row(known({MODE_FINISH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'h0002},
                  {1'b1, 16'd0, ST_OK, 5'd1}));
    add_row(known({MODE_PUSH, 8'hFF, 16'hFFFF, 4'h5, 8'hA5, 16'h0000},
                  {1'b1, 16'd3, ST_OK, 5'd2}));
    add_row(predicted({MODE_PUSH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'h0000}));
    add_row(predicted({MODE_FINISH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'h0000}));
    add_row(limit_row(5'd0));
    add_row(known({MODE_PUSH, 8'h12, 16'h3456, 4'h7, 8'h89, 16'h0000},
                  {1'b0, 16'd0, ST_FULL, 5'd2}));
    add_row(predicted({MODE_FINISH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'h0004}));
    add_row(limit_row(5'd2));
    add_row(predicted({MODE_PUSH, 8'h80, 16'h8000, 4'h8, 8'h80, 16'h0000}));
    add_row(known({MODE_PUSH, 8'h80, 16'h8000, 4'h8, 8'h80, 16'h0000},
                  {1'b0, 16'd0, ST_FULL, 5'd2}));
    add_row(known({MODE_PUSH, 8'hFF, 16'hFFFF, 4'h1, 8'hFF, 16'h0000},
                  {1'b0, 16'd0, ST_FULL, 5'd2}));
    add_row(limit_row(5'd31));
    add_row(predicted({MODE_PUSH, 8'h80, 16'h8000, 4'h8, 8'h80, 16'h0000}));
    add_row(predicted({MODE_PUSH, 8'h01, 16'h0001, 4'h0, 8'h01, 16'h0000}));
    add_row(predicted({MODE_FINISH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'h0005}));
    add_row(predicted({MODE_FINISH, 8'h00, 16'h0000, 4'h0, 8'h00, 16'h0003}));

    phase_limit    = '{5'd16, 5'd1, 5'd31, 5'd9, 5'd0, 5'd16};
    phase_limit[4] = 5'($urandom_range(1, 15));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (steps[r]) begin
      if (steps[r].is_cfg) begin
        quiesce();
        write_limit(steps[r].cfg);
      end else begin
        issue(steps[r].it, steps[r].fixed, steps[r].want);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      quiesce();
      write_limit(phase_limit[p]);
      idle_on = (p != PHASES - 1);
      for (i = 0; i < POOL; i++) begin
        pool_key[i] = 24'($urandom);
        pool_tb[i]  = 12'($urandom);
      end
      repeat (PHASE_ITEMS) issue(random_item(), 1'b0, '0);
    end

    quiesce();
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
